// ===== rtl/glyph_atlas_pixel_writer_defines.svh =====
// Assertion helpers for the glyph atlas pixel writer.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef GLYPH_ATLAS_PIXEL_WRITER_DEFINES_SVH
`define GLYPH_ATLAS_PIXEL_WRITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GAPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GAPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gapw_pkg.sv =====
package gapw_pkg;

  localparam int unsigned ADDR_W    = 18;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned DIM_W     = 8;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FMT_W     = 2;

  localparam int unsigned PALETTE_DEPTH_DEF  = 256;
  localparam int unsigned MAX_ATLAS_SIDE_DEF = 512;

  // Largest side the sizing rule ever picks.
  localparam int unsigned SIDE_LIMIT = 512;
  // A glyph cell is (width + CELL_PAD) by (height + CELL_PAD).
  localparam int unsigned CELL_PAD = 3;
  localparam int unsigned MAX_CELL = (2 ** DIM_W) - 1 + CELL_PAD;

  localparam logic [CFG_W-1:0] SIZE_STEP_128 = 24'h000400;
  localparam logic [CFG_W-1:0] SIZE_STEP_256 = 24'h001000;
  localparam logic [CFG_W-1:0] SIZE_STEP_512 = 24'h004000;

  localparam logic [DIM_W-1:0] GLYPH_HEIGHT_RST = 8'd8;
  localparam logic [DIM_W-1:0] MONO_CLAMP       = 8'd14;

  // Clamped mono level scaled to 0..255, truncated.
  localparam logic [7:0] MONO_LUT [0:14] = '{
    8'd0,   8'd18,  8'd36,  8'd54,  8'd72,  8'd91,  8'd109, 8'd127,
    8'd145, 8'd163, 8'd182, 8'd200, 8'd218, 8'd236, 8'd255
  };

  typedef enum logic [1:0] {
    ACT_BEGIN_FONT    = 2'd0,
    ACT_PALETTE_WRITE = 2'd1,
    ACT_GLYPH_START   = 2'd2,
    ACT_GLYPH_PIXEL   = 2'd3
  } action_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_MONO     = 2'd0,
    FMT_RGBA4444 = 2'd1,
    FMT_PALETTE  = 2'd2
  } pixel_format_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_FORMAT     = 2'd0,
    REG_GLYPH_HEIGHT     = 2'd1,
    REG_PIXEL_DATA_BYTES = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_PIXEL    = 1'b0,
    KIND_OVERFLOW = 1'b1
  } kind_e;

  typedef struct packed {
    action_e             action;
    logic [DIM_W-1:0]    glyph_width;
    logic [PIX_W-1:0]    pixel_value;
    logic [DIM_W-1:0]    palette_index;
    logic [COLOR_W-1:0]  palette_color;
  } in_item_t;

  typedef struct packed {
    kind_e               kind;
    logic [ADDR_W-1:0]   address;
    logic [COLOR_W-1:0]  color;
  } out_item_t;

  function automatic logic [COLOR_W-1:0] mono_color(logic [7:0] v);
    logic [3:0] lvl;
    logic [7:0] c;
    lvl = (v > MONO_CLAMP) ? 4'(MONO_CLAMP) : v[3:0];
    c   = MONO_LUT[lvl];
    return {c, c, c, c};
  endfunction

  // Each nibble times 17 is the nibble repeated.
  function automatic logic [COLOR_W-1:0] rgba4444_color(logic [PIX_W-1:0] v);
    return {v[15:12], v[15:12], v[11:8], v[11:8], v[7:4], v[7:4], v[3:0], v[3:0]};
  endfunction

endpackage

// ===== rtl/glyph_atlas_pixel_writer.sv =====
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  gapw_pkg::in_item_t
// out       output     out_valid_o/out_ready_i  gapw_pkg::out_item_t
// cfg       input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// One input beat can be taken every cycle unless an output stall has stopped the input side.
// A result enters the result stage when its beat is taken, then the output register.
// The second stage exists because the palette word is read through a register.
// Reset is asynchronous and clears control state; the palette is not cleared.
// An output stall holds the result stage and then stops the input side.
module glyph_atlas_pixel_writer #(
  parameter int unsigned PALETTE_DEPTH  = gapw_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned MAX_ATLAS_SIDE = gapw_pkg::MAX_ATLAS_SIDE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gapw_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gapw_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [gapw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gapw_pkg::CFG_W-1:0]          cfg_data_i
);
  import gapw_pkg::*;

  localparam int unsigned SIDE_CAP = (MAX_ATLAS_SIDE < SIDE_LIMIT) ? MAX_ATLAS_SIDE
                                                                   : SIDE_LIMIT;
  localparam int unsigned SIDE_W   = $clog2(SIDE_CAP + 1);
  // Coordinates can run past the side by up to two cells before overflow stops them.
  localparam int unsigned CW       = $clog2(SIDE_CAP + 2 * MAX_CELL + 1);
  localparam int unsigned PW       = CW + SIDE_W + 1;
  localparam int unsigned PIDX_W   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [DIM_W:0]  PAL_LIMIT = PALETTE_DEPTH[DIM_W:0];
  localparam logic [9:0]      CAP_10    = SIDE_CAP[9:0];
  localparam logic [CW-1:0]   PAD_C     = CELL_PAD[CW-1:0];

  // Configuration registers.
  logic [FMT_W-1:0] fmt_q;
  logic [DIM_W-1:0] height_q;
  logic [CFG_W-1:0] bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_MONO;
      height_q <= GLYPH_HEIGHT_RST;
      bytes_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PIXEL_FORMAT:     fmt_q    <= cfg_data_i[FMT_W-1:0];
        REG_GLYPH_HEIGHT:     height_q <= cfg_data_i[DIM_W-1:0];
        REG_PIXEL_DATA_BYTES: bytes_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Atlas side from the pixel count.
  logic [CFG_W-1:0]  pix_count;
  logic [9:0]        side_raw;
  logic [SIDE_W-1:0] side;

  always_comb begin
    pix_count = (fmt_q == FMT_RGBA4444) ? {1'b0, bytes_q[CFG_W-1:1]} : bytes_q;
    if (pix_count < SIZE_STEP_128) begin
      side_raw = 10'd64;
    end else if (pix_count < SIZE_STEP_256) begin
      side_raw = 10'd128;
    end else if (pix_count < SIZE_STEP_512) begin
      side_raw = 10'd256;
    end else begin
      side_raw = 10'd512;
    end
    side = (side_raw > CAP_10) ? SIDE_W'(CAP_10) : SIDE_W'(side_raw);
  end

  // Handshake: two register stages, the result stage and the output register.
  logic s1_valid_q, s1_move, in_acc;
  logic out_valid_q;

  assign s1_move    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_acc     = in_valid_i && in_ready_o;

  // Placement state.
  logic [CW-1:0]    cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [CW-1:0]    origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic [DIM_W-1:0] cur_width_q, cur_width_d, row_cnt_q, row_cnt_d;
  logic [DIM_W-1:0] col_cnt_q, col_cnt_d;
  logic             overflow_q, overflow_d;

  logic [CW-1:0]    width_c, height_c, side_c;
  logic [CW-1:0]    x_end, x_new, y_new, y_end;
  logic             fits_across, fits_down, pixel_active;
  logic [CW-1:0]    row, col;
  logic [PW-1:0]    lin_addr, side_sq_m1, masked;
  logic [PW+ADDR_W-1:0] addr_ext;

  // Result stage contents computed for the beat being accepted.
  logic               res_valid, res_pal, res_pal_ok;
  kind_e              res_kind;
  logic [ADDR_W-1:0]  res_addr;
  logic [COLOR_W-1:0] res_color;

  always_comb begin
    width_c  = CW'(in_data_i.glyph_width);
    height_c = CW'(height_q);
    side_c   = CW'(side);

    x_end       = cursor_x_q + width_c + PAD_C;
    fits_across = (x_end <= side_c);
    x_new       = fits_across ? cursor_x_q : '0;
    y_new       = fits_across ? cursor_y_q : cursor_y_q + height_c + PAD_C;
    y_end       = y_new + height_c + PAD_C;
    fits_down   = (y_end <= side_c);

    pixel_active = (cur_width_q != '0) && (row_cnt_q < height_q);
    row        = origin_y_q + CW'(1) + CW'(row_cnt_q);
    col        = origin_x_q + CW'(1) + CW'(col_cnt_q);
    lin_addr   = PW'(row) * PW'(side) + PW'(col);
    side_sq_m1 = PW'(side) * PW'(side) - PW'(1);
    masked     = lin_addr & side_sq_m1;
    addr_ext   = {{ADDR_W{1'b0}}, masked};

    cursor_x_d  = cursor_x_q;
    cursor_y_d  = cursor_y_q;
    origin_x_d  = origin_x_q;
    origin_y_d  = origin_y_q;
    cur_width_d = cur_width_q;
    row_cnt_d   = row_cnt_q;
    col_cnt_d   = col_cnt_q;
    overflow_d  = overflow_q;

    res_valid  = 1'b0;
    res_kind   = KIND_PIXEL;
    res_addr   = addr_ext[ADDR_W-1:0];
    res_color  = '0;
    res_pal    = 1'b0;
    res_pal_ok = 1'b0;

    case (in_data_i.action)
      ACT_BEGIN_FONT: begin
        cursor_x_d  = '0;
        cursor_y_d  = CW'(1);
        origin_x_d  = '0;
        origin_y_d  = CW'(1);
        cur_width_d = '0;
        row_cnt_d   = '0;
        col_cnt_d   = '0;
        overflow_d  = 1'b0;
      end
      ACT_GLYPH_START: begin
        if (!overflow_q) begin
          cursor_x_d = x_new;
          cursor_y_d = y_new;
          if (!fits_down) begin
            overflow_d  = 1'b1;
            cur_width_d = '0;
            res_valid   = 1'b1;
            res_kind    = KIND_OVERFLOW;
            res_addr    = '0;
          end else begin
            origin_x_d  = x_new;
            origin_y_d  = y_new;
            cur_width_d = in_data_i.glyph_width;
            row_cnt_d   = '0;
            col_cnt_d   = '0;
            cursor_x_d  = x_new + width_c + PAD_C;
          end
        end
      end
      ACT_GLYPH_PIXEL: begin
        if (!overflow_q && pixel_active) begin
          res_valid = 1'b1;
          case (fmt_q)
            FMT_MONO:     res_color = mono_color(in_data_i.pixel_value[7:0]);
            FMT_RGBA4444: res_color = rgba4444_color(in_data_i.pixel_value);
            FMT_PALETTE: begin
              res_pal    = 1'b1;
              res_pal_ok = ({1'b0, in_data_i.pixel_value[7:0]} < PAL_LIMIT);
            end
            default:      res_color = '0;
          endcase
          if (col_cnt_q + DIM_W'(1) >= cur_width_q) begin
            col_cnt_d = '0;
            row_cnt_d = row_cnt_q + DIM_W'(1);
          end else begin
            col_cnt_d = col_cnt_q + DIM_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q  <= '0;
      cursor_y_q  <= CW'(1);
      origin_x_q  <= '0;
      origin_y_q  <= CW'(1);
      cur_width_q <= '0;
      row_cnt_q   <= '0;
      col_cnt_q   <= '0;
      overflow_q  <= 1'b0;
    end else if (in_acc) begin
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
      origin_x_q  <= origin_x_d;
      origin_y_q  <= origin_y_d;
      cur_width_q <= cur_width_d;
      row_cnt_q   <= row_cnt_d;
      col_cnt_q   <= col_cnt_d;
      overflow_q  <= overflow_d;
    end
  end

  // Palette memory; the read word is registered with the beat that asks for it.
  logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] pal_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.action == ACT_PALETTE_WRITE &&
        {1'b0, in_data_i.palette_index} < PAL_LIMIT) begin
      pal_mem[in_data_i.palette_index[PIDX_W-1:0]] <= in_data_i.palette_color;
    end
    if (in_acc) begin
      pal_rd_q <= pal_mem[in_data_i.pixel_value[PIDX_W-1:0]];
    end
  end

  // Result stage.
  kind_e              s1_kind_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic [COLOR_W-1:0] s1_color_q;
  logic               s1_pal_q, s1_pal_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_acc && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q   <= res_kind;
      s1_addr_q   <= res_addr;
      s1_color_q  <= res_color;
      s1_pal_q    <= res_pal;
      s1_pal_ok_q <= res_pal_ok;
    end
  end

  // Output register.
  out_item_t out_q, out_d;

  always_comb begin
    out_d.kind    = s1_kind_q;
    out_d.address = s1_addr_q;
    if (s1_pal_q) begin
      out_d.color = s1_pal_ok_q ? pal_rd_q : '0;
    end else begin
      out_d.color = s1_color_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "glyph_atlas_pixel_writer_defines.svh"

  `GAPW_ASSERT_NOW(a_col_below_width, cur_width_q != '0, col_cnt_q < cur_width_q, "column count reached glyph width")
  `GAPW_ASSERT_NOW(a_overflow_no_glyph, overflow_q, cur_width_q == '0, "active glyph while overflowed")
  `GAPW_ASSERT_NEXT(a_s1_holds, s1_valid_q && out_valid_q && !out_ready_i, s1_valid_q, "result stage dropped a beat under stall")
  `GAPW_ASSERT_NOW(a_error_clean, out_valid_q && out_q.kind == KIND_OVERFLOW, out_q.address == '0 && out_q.color == '0, "error result carries data")

endmodule

// ===== tb/glyph_atlas_pixel_writer_tb.sv =====
module glyph_atlas_pixel_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gapw_pkg::*;

  localparam logic [FMT_W-1:0] FMT_UNKNOWN = 2'd3;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned STALL_LIMIT    = 5000;
  localparam int unsigned BEATS_PER_FONT = 16;

  // Tracks the atlas placement and palette, and holds the atlas writes still owed.
  class atlas_write_checker;
    logic [FMT_W-1:0]   fmt;
    logic [DIM_W-1:0]   height;
    logic [CFG_W-1:0]   data_bytes;
    logic [9:0]         cursor_x, cursor_y, origin_x, origin_y;
    logic [DIM_W-1:0]   glyph_w, rows_done, cols_done;
    bit                 overflowed;
    logic [COLOR_W-1:0] palette [PALETTE_DEPTH_DEF];
    out_item_t          pending_writes[$];
    int unsigned        fail_count;

    function new();
      fmt        = FMT_MONO;
      height     = GLYPH_HEIGHT_RST;
      data_bytes = '0;
      fail_count = 0;
      foreach (palette[i]) palette[i] = '0;
      restart_font();
    endfunction

    function void restart_font();
      cursor_x   = '0;
      cursor_y   = 10'd1;
      origin_x   = '0;
      origin_y   = 10'd1;
      glyph_w    = '0;
      rows_done  = '0;
      cols_done  = '0;
      overflowed = 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_PIXEL_FORMAT:     fmt = val[FMT_W-1:0];
        REG_GLYPH_HEIGHT:     height = val[DIM_W-1:0];
        REG_PIXEL_DATA_BYTES: data_bytes = val;
        default: ;
      endcase
    endfunction

    function int unsigned atlas_side();
      logic [CFG_W-1:0] n;
      int unsigned s;
      n = data_bytes;
      if (fmt == FMT_RGBA4444) n = n >> 1;
      if (n < SIZE_STEP_128) s = 64;
      else if (n < SIZE_STEP_256) s = 128;
      else if (n < SIZE_STEP_512) s = 256;
      else s = 512;
      if (s > MAX_ATLAS_SIDE_DEF) s = MAX_ATLAS_SIDE_DEF;
      return s;
    endfunction

    function logic [COLOR_W-1:0] pixel_color(logic [PIX_W-1:0] v);
      int unsigned lvl;
      logic [COLOR_W-1:0] c;
      c = '0;
      case (fmt)
        FMT_MONO: begin
          lvl = v[7:0];
          if (lvl > 14) lvl = 14;
          lvl = lvl * 255 / 14;
          c = {4{8'(lvl)}};
        end
        FMT_RGBA4444: begin
          for (int k = 0; k < 4; k++) c[8*k +: 8] = 8'(v[4*k +: 4]) * 8'd17;
        end
        FMT_PALETTE: c = palette[v[7:0]];
        default: c = '0;
      endcase
      return c;
    endfunction

    function void accept_beat(in_item_t it);
      int unsigned s, x, y, row, col;
      out_item_t w;
      s = atlas_side();
      case (it.action)
        ACT_BEGIN_FONT: restart_font();
        ACT_PALETTE_WRITE: palette[it.palette_index] = it.palette_color;
        ACT_GLYPH_START: begin
          if (!overflowed) begin
            x = cursor_x;
            y = cursor_y;
            // A glyph that does not fit across opens a new shelf.
            if (x + it.glyph_width + CELL_PAD > s) begin
              x = 0;
              y = y + height + CELL_PAD;
            end
            cursor_x = 10'(x);
            cursor_y = 10'(y);
            if (y + height + CELL_PAD > s) begin
              overflowed = 1'b1;
              glyph_w    = '0;
              w.kind     = KIND_OVERFLOW;
              w.address  = '0;
              w.color    = '0;
              pending_writes.push_back(w);
            end else begin
              origin_x  = cursor_x;
              origin_y  = cursor_y;
              glyph_w   = it.glyph_width;
              rows_done = '0;
              cols_done = '0;
              cursor_x  = 10'(x + it.glyph_width + CELL_PAD);
            end
          end
        end
        default: begin
          if (!overflowed && glyph_w != 0 && rows_done < height) begin
            row       = origin_y + 1 + rows_done;
            col       = origin_x + 1 + cols_done;
            w.kind    = KIND_PIXEL;
            w.address = ADDR_W'((row * s + col) & (s * s - 1));
            w.color   = pixel_color(it.pixel_value);
            pending_writes.push_back(w);
            cols_done++;
            if (cols_done >= glyph_w) begin
              cols_done = '0;
              rows_done++;
            end
          end
        end
      endcase
    endfunction

    function void check_write(out_item_t got);
      out_item_t want;
      if (pending_writes.size() == 0) begin
        $error("unexpected atlas beat: kind %0d address %0h color %08h",
               got.kind, got.address, got.color);
        fail_count++;
        return;
      end
      want = pending_writes.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind mismatch: expected %0d actual %0d", want.kind, got.kind);
        fail_count++;
      end
      if (got.address !== want.address) begin
        $error("address mismatch: expected %0h actual %0h", want.address, got.address);
        fail_count++;
      end
      if (got.color !== want.color) begin
        $error("color mismatch: expected %08h actual %08h", want.color, got.color);
        fail_count++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  atlas_write_checker sb = new();
  int unsigned in_idle_pct  = 13;
  int unsigned out_idle_pct = 13;
  int unsigned beats_sent   = 0;
  int unsigned quiet_cycles = 0;

  glyph_atlas_pixel_writer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  // Both channels are sampled at the rising edge; the watchdog counts edges with no beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.accept_beat(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_write(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("glyph_atlas_pixel_writer verification failed");
        $finish;
      end
    end
  end

  function automatic in_item_t random_beat(action_e a);
    in_item_t it;
    it.action        = a;
    it.glyph_width   = 8'($urandom);
    it.pixel_value   = 16'($urandom);
    it.palette_index = 8'($urandom);
    it.palette_color = $urandom;
    return it;
  endfunction

  // Entered and left at a falling edge; valid stays high into the next beat.
  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] v);
    in_item_t it;
    it = random_beat(ACT_GLYPH_PIXEL);
    it.pixel_value = v;
    send_beat(it);
  endtask

  task automatic send_glyph_start(logic [DIM_W-1:0] w);
    in_item_t it;
    it = random_beat(ACT_GLYPH_START);
    it.glyph_width = w;
    send_beat(it);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.pending_writes.size() != 0) @(negedge clk_i);
    // Beats that make no write may still be in the pipeline.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [FMT_W-1:0] fmt, logic [DIM_W-1:0] h, logic [CFG_W-1:0] bytes);
    wait_for_results();
    write_reg(REG_PIXEL_FORMAT, CFG_W'(fmt));
    write_reg(REG_GLYPH_HEIGHT, CFG_W'(h));
    write_reg(REG_PIXEL_DATA_BYTES, bytes);
  endtask

  // Mostly complete glyphs with random pixels, mixed with partial glyphs and noise.
  task automatic send_font(int unsigned n);
    int unsigned last_beat, full, cnt, r;
    logic [DIM_W-1:0] w;
    last_beat = beats_sent + n;
    send_beat(random_beat(ACT_BEGIN_FONT));
    while (beats_sent < last_beat) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_beat(random_beat(ACT_BEGIN_FONT));
      end else if (r < 9) begin
        send_beat(random_beat(ACT_PALETTE_WRITE));
      end else if (r < 15) begin
        send_beat(random_beat(action_e'($urandom_range(0, 3))));
      end else begin
        r = $urandom_range(99);
        if (r < 6) w = '0;
        else if (r < 75) w = 8'($urandom_range(1, 6));
        else w = 8'($urandom_range(7, 255));
        send_glyph_start(w);
        full = w * sb.height;
        if (full <= 40 && $urandom_range(9) != 0) begin
          cnt = full + (($urandom_range(7) == 0) ? 1 : 0);
        end else begin
          cnt = $urandom_range(0, 16);
        end
        repeat (cnt) send_pixel(16'($urandom));
      end
    end
  endtask

  initial begin
    in_item_t it;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats at the reset settings: mono, height 8, 64 by 64 atlas.
    send_beat(random_beat(ACT_BEGIN_FONT));
    send_pixel(16'h0003);
    it = random_beat(ACT_PALETTE_WRITE);
    it.palette_index = 8'd0;
    it.palette_color = 32'hFFFF_FFFF;
    send_beat(it);
    it = random_beat(ACT_PALETTE_WRITE);
    it.palette_index = 8'd255;
    send_beat(it);
    send_glyph_start(8'd0);
    send_pixel(16'h0005);
    send_glyph_start(8'd1);
    send_pixel(16'h0000);
    send_pixel(16'h000E);
    send_pixel(16'h000F);
    send_pixel(16'hFFFF);
    send_pixel(16'h00FF);
    send_pixel(16'h0007);
    send_pixel(16'hFF0E);
    send_pixel(16'($urandom));
    send_pixel(16'h0009);
    // Over-wide glyphs stack shelves until the atlas runs out of rows.
    send_glyph_start(8'd255);
    send_pixel(16'($urandom));
    send_pixel(16'($urandom));
    repeat (4) send_glyph_start(8'd255);
    send_pixel(16'h000A);
    send_glyph_start(8'd2);

    // Fill the whole palette so every later lookup hits a written entry.
    for (int i = 0; i < PALETTE_DEPTH_DEF; i++) begin
      it = random_beat(ACT_PALETTE_WRITE);
      it.palette_index = 8'(i);
      send_beat(it);
    end

    configure(FMT_MONO, 8'd1, 24'h000000);
    send_font(BEATS_PER_FONT);
    configure(FMT_RGBA4444, 8'd4, 24'h0007FF);
    send_font(BEATS_PER_FONT);
    configure(FMT_PALETTE, 8'd2, 24'h000400);
    send_font(25);
    wait_for_results();
    send_font(25);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    configure(FMT_RGBA4444, 8'd3, 24'h002000);
    send_font(60);
    in_idle_pct  = 13;
    out_idle_pct = 13;

    configure(FMT_UNKNOWN, 8'd5, 24'h003FFF);
    send_font(BEATS_PER_FONT);
    configure(FMT_PALETTE, 8'd0, 24'hFFFFFF);
    send_font(30);
    configure(FMT_MONO, 8'd255, 24'h004000);
    send_font(BEATS_PER_FONT);
    configure(FMT_PALETTE, 8'd255, 24'h000000);
    send_font(20);
    configure(FMT_RGBA4444, 8'd6, 24'h000FFF);
    send_font(BEATS_PER_FONT);
    repeat (2) begin
      configure(FMT_W'($urandom_range(0, 3)), 8'($urandom_range(1, 12)), 24'($urandom));
      send_font(BEATS_PER_FONT);
    end

    wait_for_results();
    repeat (8) @(negedge clk_i);
    if (sb.pending_writes.size() != 0) begin
      $error("%0d atlas writes never arrived", sb.pending_writes.size());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("glyph_atlas_pixel_writer verification clean");
    end else begin
      $display("glyph_atlas_pixel_writer verification failed");
    end
    $finish;
  end

endmodule
